// File: rtl/yaz0_stream_decompressor_unit_assert.svh
// assertion macros for the yaz0 stream decompressor
// used by the top level only
`ifndef YAZ0_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define YAZ0_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
// implication checked on every clock edge out of reset
`define Y0_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define Y0_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/yaz0_pkg.sv
// package for the yaz0 stream decompressor: types and constants
// no dependencies
`timescale 1ns / 1ps
package yaz0_pkg;
  localparam int unsigned HdrLen = 16;
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_REF2   = 2'd2,
    PH_REF3   = 2'd3
  } phase_e;
  // command from the parser to the copy engine
  typedef struct packed {
    logic        is_ref;
    logic        err;
    logic [7:0]  lit;
    logic [11:0] ofs;    // distance minus one
    logic [8:0]  len;
  } cmd_t;
  typedef enum logic [1:0] {
    EN_IDLE = 2'd0,
    EN_RUN  = 2'd1,
    EN_FLSH = 2'd2
  } eng_e;
endpackage

// File: rtl/yaz0_parse.sv
// front part: header, code byte and token parsing into copy commands
// depends on yaz0_pkg
`timescale 1ns / 1ps
module yaz0_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               stream_start_i,
  input  logic               eng_busy_i,
  input  logic [31:0]        out_count_i,
  input  logic               done_i,
  output logic               start_o,
  output logic [31:0]        size_o,
  output logic               hdr_end_o,
  output logic               cmd_valid_o,
  output yaz0_pkg::cmd_t     cmd_o,
  input  logic               cmd_stall_i
);
  yaz0_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [7:0]  bits_q, bits_d, mask_q, mask_d;
  logic [15:0] tok_q, tok_d;
  logic [31:0] size_q, size_d;
  logic        acc, done_eff;
  logic [12:0] dist1;

  // the engine must have finished so out_count and done are settled
  assign in_stall_o = eng_busy_i | cmd_stall_i;
  assign acc = in_valid_i & ~in_stall_o;
  assign start_o = acc & stream_start_i;
  assign size_o = size_d;

  // parser next state
  always_comb begin
    phase_d = phase_q; hcnt_d = hcnt_q; bits_d = bits_q; mask_d = mask_q;
    tok_d = tok_q; size_d = size_q;
    cmd_valid_o = 1'b0; cmd_o = '0; hdr_end_o = 1'b0;
    done_eff = done_i;
    dist1 = '0;
    if (acc && stream_start_i) begin
      phase_d = yaz0_pkg::PH_HEADER; hcnt_d = '0; bits_d = '0; mask_d = '0;
      tok_d = '0; size_d = '0; done_eff = 1'b0;
    end
    if (acc && !done_eff) begin
      case (phase_d)
        yaz0_pkg::PH_TOKEN: begin
          if (mask_d == '0) begin
            bits_d = in_byte_i; mask_d = 8'h80;
          end else if ((bits_d & mask_d) != '0) begin
            mask_d = mask_d >> 1;
            cmd_valid_o = 1'b1; cmd_o.lit = in_byte_i; cmd_o.len = 9'd1;
          end else begin
            tok_d = {in_byte_i, 8'h00}; phase_d = yaz0_pkg::PH_REF2;
          end
        end
        yaz0_pkg::PH_REF2: begin
          tok_d = {tok_d[15:8], in_byte_i};
          if (tok_d[15:12] != '0) begin
            mask_d = mask_d >> 1; phase_d = yaz0_pkg::PH_TOKEN;
            cmd_valid_o = 1'b1; cmd_o.is_ref = 1'b1;
            cmd_o.len = 9'(tok_d[15:12]) + 9'd2;
          end else begin
            phase_d = yaz0_pkg::PH_REF3;
          end
        end
        yaz0_pkg::PH_REF3: begin
          mask_d = mask_d >> 1; phase_d = yaz0_pkg::PH_TOKEN;
          cmd_valid_o = 1'b1; cmd_o.is_ref = 1'b1;
          cmd_o.len = 9'(in_byte_i) + 9'd18;
        end
        default: begin
          if (hcnt_d[3:2] == 2'b01) size_d = {size_d[23:0], in_byte_i};
          hcnt_d = hcnt_d + 4'd1;
          if (hcnt_d == '0) begin
            phase_d = yaz0_pkg::PH_TOKEN; mask_d = '0; hdr_end_o = 1'b1;
          end else begin
            phase_d = yaz0_pkg::PH_HEADER;
          end
        end
      endcase
      cmd_o.ofs = tok_d[11:0];
      dist1 = 13'(tok_d[11:0]) + 13'd1;
      if (cmd_o.is_ref && (stream_start_i || {19'd0, dist1} > out_count_i))
        cmd_o.err = 1'b1;
    end
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= yaz0_pkg::PH_HEADER; hcnt_q <= '0; bits_q <= '0; mask_q <= '0;
      tok_q <= '0; size_q <= '0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; bits_q <= bits_d; mask_q <= mask_d;
      tok_q <= tok_d; size_q <= size_d;
    end
  end
endmodule

// File: rtl/yaz0_cmd_fifo.sv
// two-entry command queue between parser and copy engine
// depends on yaz0_pkg
`timescale 1ns / 1ps
module yaz0_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  yaz0_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_i,
  output yaz0_pkg::cmd_t rd_data_o
);
  yaz0_pkg::cmd_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_stall_o = cnt_q[1];
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i & ~cnt_q[1];
  assign rd = rd_i & rd_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// File: rtl/yaz0_copy.sv
// back part: copy engine with 4096-byte history and output register
// depends on yaz0_pkg
`timescale 1ns / 1ps
module yaz0_copy #(
  parameter int unsigned OutLanes = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       size_i,
  input  logic              hdr_end_i,
  input  logic              cmd_valid_i,
  input  yaz0_pkg::cmd_t    cmd_i,
  output logic              cmd_rd_o,
  output logic              busy_o,
  output logic [31:0]       out_count_o,
  output logic              done_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        lane_o [8],
  output logic [3:0]        byte_count_o,
  output logic              run_last_o,
  output logic              stream_done_o,
  output logic              ref_error_o
);
  localparam int unsigned FillW = $clog2(OutLanes + 1);
  logic [7:0]  hist_q [4096];
  yaz0_pkg::eng_e st_q, st_d;
  logic [31:0] cnt_q, cnt_d, size_q;
  logic        done_q, done_d;
  logic [8:0]  rem_q, rem_d;
  logic [11:0] dist_q;
  logic        isref_q;
  logic [7:0]  lit_q;
  logic [7:0]  acc_q [8];
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]  rdat_q, b;
  logic        pend_q, pend_d;   // a read issued last cycle
  logic [11:0] wa_q;             // write address of the byte in flight
  logic        ov_q, ov_d;
  logic        emit, free, put, last, cut;

  assign free = ~ov_q | ~out_stall_i;
  assign out_valid_o = ov_q;
  assign busy_o = st_q != yaz0_pkg::EN_IDLE || cmd_valid_i || pend_q;
  assign out_count_o = cnt_q;
  assign done_o = done_q;
  assign b = isref_q ? rdat_q : lit_q;

  // history read is registered in the cycle before its use; bytes never overlap because
  // a new read only issues after the previous write
  always_ff @(posedge clk_i) begin
    rdat_q <= hist_q[cnt_q[11:0] - dist_q - 12'd1];
    if (pend_q) hist_q[wa_q] <= b;
  end

  // engine control
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; done_d = done_q; rem_d = rem_q;
    fill_d = fill_q; pend_d = 1'b0; ov_d = ov_q & out_stall_i;
    cmd_rd_o = 1'b0; emit = 1'b0; put = 1'b0; last = 1'b0; cut = 1'b0;
    case (st_q)
      yaz0_pkg::EN_IDLE: begin
        if (cmd_valid_i && free) begin
          cmd_rd_o = 1'b1;
          if (cmd_i.err) begin
            emit = 1'b1;
          end else begin
            rem_d = cmd_i.len; fill_d = '0; st_d = yaz0_pkg::EN_RUN;
          end
        end
      end
      yaz0_pkg::EN_RUN: begin
        // each byte in turn: read, then write; the next read waits for the write
        if (pend_q) begin
          put = 1'b1;
          cnt_d = cnt_q + 32'd1; rem_d = rem_q - 9'd1; fill_d = fill_q + FillW'(1);
          cut = (rem_q == 9'd1) || (cnt_d >= size_q);
          if (cut || fill_d == FillW'(OutLanes)) st_d = yaz0_pkg::EN_FLSH;
        end else if (rem_q == '0 || cnt_q >= size_q) begin
          st_d = yaz0_pkg::EN_FLSH;
        end else begin
          pend_d = 1'b1;
        end
      end
      yaz0_pkg::EN_FLSH: begin
        if (free) begin
          last = (rem_q == '0) || (cnt_q >= size_q);
          if (fill_q != '0) emit = 1'b1;
          fill_d = '0;
          if (last) begin
            st_d = yaz0_pkg::EN_IDLE;
            if (cnt_q >= size_q) done_d = 1'b1;
          end else begin
            st_d = yaz0_pkg::EN_RUN;
          end
        end
      end
      default: st_d = yaz0_pkg::EN_IDLE;
    endcase
    if (emit) ov_d = 1'b1;
    if (start_i) begin
      cnt_d = '0; done_d = 1'b0;
    end
    if (hdr_end_i) begin
      cnt_d = '0;
      if (size_i == '0) done_d = 1'b1;
    end
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= yaz0_pkg::EN_IDLE; cnt_q <= '0; done_q <= 1'b0; rem_q <= '0;
      fill_q <= '0; pend_q <= 1'b0; ov_q <= 1'b0; size_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; done_q <= done_d; rem_q <= rem_d;
      fill_q <= fill_d; pend_q <= pend_d; ov_q <= ov_d;
      if (start_i || hdr_end_i) size_q <= size_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      dist_q <= cmd_i.ofs; isref_q <= cmd_i.is_ref; lit_q <= cmd_i.lit;
    end
    if (pend_d) wa_q <= cnt_q[11:0];
    if (put) acc_q[fill_q[2:0]] <= b;
    if (emit) begin
      for (int i = 0; i < 8; i++)
        lane_o[i] <= (cmd_rd_o || i >= int'(fill_q)) ? 8'd0 : acc_q[i];
      byte_count_o <= cmd_rd_o ? 4'd0 : 4'(fill_q);
      run_last_o <= cmd_rd_o ? 1'b1 : last;
      stream_done_o <= cmd_rd_o ? 1'b0 : (last && cnt_q >= size_q);
      ref_error_o <= cmd_rd_o;
    end
  end
endmodule

// File: rtl/yaz0_stream_decompressor_unit.sv
// top level of the yaz0 stream decompressor: parser, queue, copy engine
// depends on yaz0_pkg, yaz0_parse, yaz0_cmd_fifo, yaz0_copy and the assert header
//
//  channel | direction | payload
//  in      | input     | in_byte_i, stream_start_i
//  out     | output    | lane0..7_o, byte_count_o, run_last_o, stream_done_o, ref_error_o
//
// header and code bytes are taken by the parser alone; literals and references pass the queue
// and the copy engine, which copies each byte by a history read then a write and flushes each result.
// the next input byte waits until the copy engine has finished the previous run.
// reset clears all control state; history content is undefined until written.
// output stalls hold the result register and pause the copy engine before it flushes or takes a command.
`timescale 1ns / 1ps
`include "yaz0_stream_decompressor_unit_assert.svh"
module yaz0_stream_decompressor_unit #(
  parameter int unsigned OUT_LANES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] lane0_o,
  output logic [7:0] lane1_o,
  output logic [7:0] lane2_o,
  output logic [7:0] lane3_o,
  output logic [7:0] lane4_o,
  output logic [7:0] lane5_o,
  output logic [7:0] lane6_o,
  output logic [7:0] lane7_o,
  output logic [3:0] byte_count_o,
  output logic       run_last_o,
  output logic       stream_done_o,
  output logic       ref_error_o
);
  yaz0_pkg::cmd_t cmd_w, cmd_r;
  logic cmd_v, cmd_st, rd_v, rd, busy, start, hdr_end, done;
  logic [31:0] size, ocnt;
  logic [7:0] lanes [8];

  yaz0_parse u_parse (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_byte_i, .stream_start_i,
    .eng_busy_i(busy | rd_v), .out_count_i(ocnt), .done_i(done),
    .start_o(start), .size_o(size), .hdr_end_o(hdr_end),
    .cmd_valid_o(cmd_v), .cmd_o(cmd_w), .cmd_stall_i(cmd_st)
  );

  yaz0_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(cmd_v), .wr_stall_o(cmd_st), .wr_data_i(cmd_w),
    .rd_valid_o(rd_v), .rd_i(rd), .rd_data_o(cmd_r)
  );

  yaz0_copy #(.OutLanes(OUT_LANES)) u_copy (
    .clk_i, .rst_ni, .start_i(start), .size_i(size), .hdr_end_i(hdr_end),
    .cmd_valid_i(rd_v), .cmd_i(cmd_r), .cmd_rd_o(rd), .busy_o(busy),
    .out_count_o(ocnt), .done_o(done), .out_valid_o, .out_stall_i,
    .lane_o(lanes), .byte_count_o, .run_last_o, .stream_done_o, .ref_error_o
  );

  assign lane0_o = lanes[0];
  assign lane1_o = lanes[1];
  assign lane2_o = lanes[2];
  assign lane3_o = lanes[3];
  assign lane4_o = lanes[4];
  assign lane5_o = lanes[5];
  assign lane6_o = lanes[6];
  assign lane7_o = lanes[7];

  // checks
  `Y0_ASSERT_IMP(a_err_empty, out_valid_o && ref_error_o, byte_count_o == 4'd0 && run_last_o)
  `Y0_ASSERT_IMP(a_done_last, out_valid_o && stream_done_o, run_last_o && !ref_error_o)
  `Y0_ASSERT_IMP(a_busy_stall, busy, in_stall_o)
endmodule
